// File: rtl/lbp_pkg.sv
// lbp_pkg: sizes, beat structs, register indexes and line store types
// for the 3x3 local binary pattern unit; depends on nothing
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W   = 8;
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = CIDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] pattern_code;
    logic              frame_end;
  } out_beat_t;

  // one line store entry: pixel two rows up and pixel one row up
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_pair_t       data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } ram_rd_t;

  // last valid index for a register value clamped to [MIN_DIM, hi]
  function automatic logic [31:0] dim_last(input logic [CFG_W-1:0] v, input int hi);
    logic [31:0] lim;
    if (32'(v) < 32'(MIN_DIM)) begin
      lim = 32'(MIN_DIM);
    end else if (32'(v) > 32'(hi)) begin
      lim = 32'(hi);
    end else begin
      lim = 32'(v);
    end
    return lim - 32'd1;
  endfunction

endpackage

// File: rtl/lbp_code_3x3_unit.sv
// lbp_code_3x3_unit: streaming 3x3 local binary pattern, top level
// uses lbp_pkg and lbp_line_ram
//
//   channel  ports                          beat
//   in       in_valid in_ready in_data      pixel, frame_start
//   out      out_valid out_ready out_data   pattern_code, frame_end
//   cfg      cfg_valid cfg_ready cfg_index  cfg_data (width, height)
//
// one pixel per cycle while the output is not stalled; a code passes the pixel stage, then the output register
// line store read at acceptance, written back as the pixel stage advances, same entry forwarded
// reset clears counters, window and handshakes; line store has no clearing pass
// input stalls only while a code waits in the output register and is not taken
module lbp_code_3x3_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lbp_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lbp_pkg::out_beat_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [lbp_pkg::CFG_W-1:0]     cfg_data
);

  logic [lbp_pkg::CFG_W-1:0] width_r, height_r;
  logic [lbp_pkg::COL_W-1:0] col_r, col_nxt, w_last;
  logic [lbp_pkg::ROW_W-1:0] row_r, row_nxt, h_last;
  logic [lbp_pkg::COL_W-1:0] c_cur;
  logic [lbp_pkg::ROW_W-1:0] r_cur;
  logic                      accept;

  logic                      s1_valid_r;
  logic [lbp_pkg::PIX_W-1:0] s1_px_r;
  logic [lbp_pkg::COL_W-1:0] s1_col_r;
  logic                      s1_emit_r, s1_end_r;
  logic                      s1_adv;

  logic                      fwd_sel_r;
  lbp_pkg::line_pair_t       fwd_data_r;
  lbp_pkg::line_pair_t       ram_q, col_data;
  lbp_pkg::ram_wr_t          ram_wr;
  lbp_pkg::ram_rd_t          ram_rd;

  // window columns: index 0 upper, 1 middle, 2 lower
  logic [lbp_pkg::PIX_W-1:0] win1_r [3];
  logic [lbp_pkg::PIX_W-1:0] win2_r [3];
  logic [lbp_pkg::CODE_W-1:0] code;
  logic [lbp_pkg::PIX_W-1:0]  ce;

  logic                      out_valid_r;
  lbp_pkg::out_beat_t        out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lbp_pkg::WIDTH_RST;
      height_r <= lbp_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbp_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        lbp_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_last = lbp_pkg::COL_W'(lbp_pkg::dim_last(width_r, lbp_pkg::MAX_WIDTH));
  assign h_last = lbp_pkg::ROW_W'(lbp_pkg::dim_last(height_r, lbp_pkg::MAX_HEIGHT));

  // position counters
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign c_cur = in_data.frame_start ? '0 : col_r;
  assign r_cur = in_data.frame_start ? '0 : row_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (c_cur >= w_last) begin
        col_nxt = '0;
        row_nxt = (r_cur >= h_last) ? '0 : r_cur + lbp_pkg::ROW_W'(1);
      end else begin
        col_nxt = c_cur + lbp_pkg::COL_W'(1);
        row_nxt = r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store access
  assign ram_rd.en   = accept;
  assign ram_rd.addr = c_cur;
  assign ram_wr.en   = s1_adv;
  assign ram_wr.addr = s1_col_r;
  assign ram_wr.data = '{upper: col_data.middle, middle: s1_px_r};

  lbp_line_ram u_line_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_q)
  );

  // write in flight to the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (accept) begin
      fwd_sel_r <= s1_valid_r && (s1_col_r == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= ram_wr.data;
    end
  end

  assign col_data = fwd_sel_r ? fwd_data_r : ram_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_data.pixel;
      s1_col_r  <= c_cur;
      s1_emit_r <= (r_cur >= lbp_pkg::ROW_W'(2)) && (c_cur >= lbp_pkg::COL_W'(2));
      s1_end_r  <= (r_cur >= h_last) && (c_cur >= w_last);
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win1_r[k] <= '0;
        win2_r[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win1_r[k] <= win2_r[k];
      end
      win2_r[0] <= col_data.upper;
      win2_r[1] <= col_data.middle;
      win2_r[2] <= s1_px_r;
    end
  end

  // centre at or above neighbour sets the bit
  assign ce = win2_r[1];
  always_comb begin
    code[0] = ce >= win1_r[1];
    code[1] = ce >= win1_r[2];
    code[2] = ce >= win2_r[2];
    code[3] = ce >= s1_px_r;
    code[4] = ce >= col_data.middle;
    code[5] = ce >= col_data.upper;
    code[6] = ce >= win2_r[0];
    code[7] = ce >= win1_r[0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_data_r <= '{pattern_code: code, frame_end: s1_end_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> out_valid_r && !out_ready)
    else $error("pixel stage held with room at the output");

  a_code_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_emit_r |=> out_valid_r)
    else $error("interior pixel left no code");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_px_r))
    else $error("held pixel stage overwritten");

endmodule

// File: rtl/lbp_line_ram.sv
// lbp_line_ram: single store for both previous image rows, one entry per column
// one write and one registered read per cycle; depends on lbp_pkg
module lbp_line_ram (
  input  logic                clk,
  input  lbp_pkg::ram_wr_t    wr,
  input  lbp_pkg::ram_rd_t    rd,
  output lbp_pkg::line_pair_t rd_data
);

  lbp_pkg::line_pair_t mem [lbp_pkg::MAX_WIDTH];
  lbp_pkg::line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for lbp_code_3x3_unit, 3x3 local binary pattern
// depends on lbp_pkg and the unit rtl; a tracker class predicts every code beat
// and checks the result beats in order, with random gaps on both channels
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lbp_pkg::CIDX_W-1:0] CFG_SPARE_A = lbp_pkg::CIDX_W'(2);
  localparam logic [lbp_pkg::CIDX_W-1:0] CFG_SPARE_B = lbp_pkg::CIDX_W'(3);
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_PIX   = 1500;
  localparam int SETTLE_TICKS = 8;

  // raster order per frame: upper-left, above, upper-right, left, centre,
  // right, lower-left, below, lower-right
  localparam logic [lbp_pkg::PIX_W-1:0] DIRECTED_PIX [27] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd128, 8'd129, 8'd127, 8'd255, 8'd128, 8'd0,   8'd127, 8'd128, 8'd129
  };

  class lbp_code_tracker;
    logic [lbp_pkg::CFG_W-1:0] width_setting  = lbp_pkg::WIDTH_RST;
    logic [lbp_pkg::CFG_W-1:0] height_setting = lbp_pkg::HEIGHT_RST;
    logic [lbp_pkg::PIX_W-1:0] upper_line [lbp_pkg::MAX_WIDTH];
    logic [lbp_pkg::PIX_W-1:0] middle_line [lbp_pkg::MAX_WIDTH];
    logic [lbp_pkg::PIX_W-1:0] tile [3][3];
    int x_pos;
    int y_pos;
    int mismatches;
    lbp_pkg::out_beat_t codes_due [$];

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (tile[i, j]) tile[i][j] = '0;
      x_pos      = 0;
      y_pos      = 0;
      mismatches = 0;
    endfunction

    static function int fit_dim(input logic [lbp_pkg::CFG_W-1:0] v, input int hi);
      if (int'(v) < lbp_pkg::MIN_DIM) return lbp_pkg::MIN_DIM;
      if (int'(v) > hi) return hi;
      return int'(v);
    endfunction

    function int cols();
      return fit_dim(width_setting, lbp_pkg::MAX_WIDTH);
    endfunction

    function int rows();
      return fit_dim(height_setting, lbp_pkg::MAX_HEIGHT);
    endfunction

    function int pending();
      return codes_due.size();
    endfunction

    function void write_reg(input logic [lbp_pkg::CIDX_W-1:0] idx,
                            input logic [lbp_pkg::CFG_W-1:0] val);
      case (idx)
        lbp_pkg::CFG_IMAGE_WIDTH: begin
          width_setting = val;
        end
        lbp_pkg::CFG_IMAGE_HEIGHT: begin
          height_setting = val;
        end
        default: begin
        end
      endcase
    endfunction

    function void take_pixel(input lbp_pkg::in_beat_t beat);
      int w;
      int h;
      int c;
      int r;
      logic [lbp_pkg::PIX_W-1:0] up;
      logic [lbp_pkg::PIX_W-1:0] mid;
      logic [lbp_pkg::PIX_W-1:0] ce;
      lbp_pkg::out_beat_t due;
      w = cols();
      h = rows();
      if (beat.frame_start) begin
        x_pos = 0;
        y_pos = 0;
      end
      c   = x_pos;
      r   = y_pos;
      up  = upper_line[c];
      mid = middle_line[c];
      for (int k = 0; k < 3; k++) begin
        tile[k][0] = tile[k][1];
        tile[k][1] = tile[k][2];
      end
      tile[0][2] = up;
      tile[1][2] = mid;
      tile[2][2] = beat.pixel;
      upper_line[c]  = mid;
      middle_line[c] = beat.pixel;
      if (r >= 2 && c >= 2) begin
        ce = tile[1][1];
        due.pattern_code = {ce >= tile[0][0], ce >= tile[0][1], ce >= tile[0][2],
                            ce >= tile[1][2], ce >= tile[2][2], ce >= tile[2][1],
                            ce >= tile[2][0], ce >= tile[1][0]};
        due.frame_end = (r >= h - 1) && (c >= w - 1);
        codes_due.push_back(due);
      end
      if (c >= w - 1) begin
        x_pos = 0;
        y_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
        x_pos = c + 1;
      end
    endfunction

    task report_mismatch(input string msg);
      if (mismatches < 40) $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_code(input lbp_pkg::out_beat_t got);
      lbp_pkg::out_beat_t want;
      if (codes_due.size() == 0) begin
        report_mismatch($sformatf("code beat %h with nothing due", got.pattern_code));
      end else begin
        want = codes_due.pop_front();
        if (got.pattern_code !== want.pattern_code)
          report_mismatch($sformatf("pattern_code got %h want %h",
                                    got.pattern_code, want.pattern_code));
        if (got.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end got %b want %b (code %h)",
                                    got.frame_end, want.frame_end, want.pattern_code));
      end
    endtask
  endclass

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  lbp_pkg::in_beat_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  lbp_pkg::out_beat_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lbp_pkg::CIDX_W-1:0]     cfg_index = '0;
  logic [lbp_pkg::CFG_W-1:0]      cfg_data  = '0;

  lbp_code_tracker tracker;
  logic no_gaps = 1'b0;
  int   pixels_sent = 0;
  int   quiet_ticks = 0;

  lbp_code_3x3_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(0, 99) >= 32);
    if (rst_n && out_valid && out_ready) tracker.check_code(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_ticks <= 0;
      end else if (quiet_ticks >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_ticks <= quiet_ticks + 1;
      end
    end
  end

  task automatic cfg_beat(input logic [lbp_pkg::CIDX_W-1:0] idx,
                          input logic [lbp_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // spare indexes go last so that any aliasing onto a real register shows
  task automatic set_frame_size(input logic [lbp_pkg::CFG_W-1:0] w,
                                input logic [lbp_pkg::CFG_W-1:0] h,
                                input bit poke_spare);
    cfg_beat(lbp_pkg::CFG_IMAGE_WIDTH, w);
    cfg_beat(lbp_pkg::CFG_IMAGE_HEIGHT, h);
    if (poke_spare) begin
      cfg_beat(CFG_SPARE_A, lbp_pkg::CFG_W'($urandom));
      cfg_beat(CFG_SPARE_B, lbp_pkg::CFG_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [lbp_pkg::PIX_W-1:0] px, input logic fs);
    lbp_pkg::in_beat_t beat;
    beat.pixel       = px;
    beat.frame_start = fs;
    while (!no_gaps && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_pixel(beat);
  endtask

  // wait for every due code, then let the pipeline settle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic stream_frames(input int frames, input bit noisy);
    int n;
    int style;
    bit start;
    logic fs;
    logic [lbp_pkg::PIX_W-1:0] base;
    logic [lbp_pkg::PIX_W-1:0] px;
    n = tracker.cols() * tracker.rows();
    for (int f = 0; f < frames; f++) begin
      style = $urandom_range(0, 2);
      base  = lbp_pkg::PIX_W'($urandom_range(0, 253));
      start = (f == 0) || ($urandom_range(0, 1) == 1);
      for (int i = 0; i < n; i++) begin
        fs = (i == 0 && start) || (noisy && $urandom_range(0, 199) == 0);
        case (style)
          0: begin
            px = lbp_pkg::PIX_W'($urandom_range(0, 255));
          end
          1: begin
            px = base + lbp_pkg::PIX_W'($urandom_range(0, 2));
          end
          default: begin
            px = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
          end
        endcase
        if (noisy) no_gaps <= (pixels_sent >= 500) && (pixels_sent < 850);
        send_pixel(px, fs);
        pixels_sent++;
      end
    end
  endtask

  // opening stretch of a frame too large to finish, starting at row 0, column 0
  task automatic stream_part(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(lbp_pkg::PIX_W'($urandom_range(0, 255)), (i == 0));
      pixels_sent++;
    end
  endtask

  initial begin
    int phase;
    logic [lbp_pkg::CFG_W-1:0] w_reg;
    logic [lbp_pkg::CFG_W-1:0] h_reg;
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_frame_size(lbp_pkg::CFG_W'(3), lbp_pkg::CFG_W'(3), 1'b1);
    for (int i = 0; i < 27; i++) send_pixel(DIRECTED_PIX[i], (i == 0) || (i == 18));
    drain();

    phase = 0;
    while (pixels_sent < RANDOM_PIX) begin
      case ($urandom_range(0, 7))
        0: begin
          w_reg = lbp_pkg::CFG_W'($urandom_range(0, 2));
          h_reg = lbp_pkg::CFG_W'($urandom_range(0, 5));
        end
        1: begin
          w_reg = lbp_pkg::CFG_W'($urandom_range(13, 48));
          h_reg = lbp_pkg::CFG_W'($urandom_range(3, 5));
        end
        default: begin
          w_reg = lbp_pkg::CFG_W'($urandom_range(3, 12));
          h_reg = lbp_pkg::CFG_W'($urandom_range(3, 8));
        end
      endcase
      set_frame_size(w_reg, h_reg, (phase % 4) == 0);
      stream_frames($urandom_range(1, 4), 1'b1);
      drain();
      phase++;
    end
    no_gaps <= 1'b0;

    // clamped extremes: start of the widest row, start of the tallest frame,
    // all-zero and tiny registers
    set_frame_size(lbp_pkg::CFG_W'(2047), lbp_pkg::CFG_W'(3), 1'b0);
    stream_part(40);
    drain();
    set_frame_size(lbp_pkg::CFG_W'(3), lbp_pkg::CFG_W'(2047), 1'b1);
    stream_part(36);
    drain();
    set_frame_size(lbp_pkg::CFG_W'(0), lbp_pkg::CFG_W'(0), 1'b0);
    stream_frames(2, 1'b0);
    drain();
    set_frame_size(lbp_pkg::CFG_W'(1), lbp_pkg::CFG_W'(2), 1'b1);
    stream_frames(2, 1'b0);
    drain();

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
